[sv/modular_arithmetic_unit_assert.svh]
// assertion macros for the modular arithmetic unit rtl
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle property, disabled during reset
`define MAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// next-cycle implication, disabled during reset
`define MAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MAU_ASSERT(lbl, clk, rst, prop, msg)
`define MAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[sv/mau_pkg.sv]
// shared types and constants of the modular arithmetic unit
package mau_pkg;

   localparam int MOD_WIDTH     = 16;
   localparam int OPERAND_WIDTH = 32;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

   // operation codes
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_INV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_FIX,
      ST_MUL,
      ST_INV,
      ST_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic red_step;
      logic fix;
      logic mul_step;
      logic inv_step;
      logic inv_fail;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic red_last;
      logic mul_last;
      logic is_mul;
      logic is_inv;
      logic inv_hit;
      logic inv_end;
      logic rsp_busy;
   } dp_status_type;

endpackage

[sv/modular_arithmetic_unit.sv]
// top level of the modular arithmetic unit
// sequence: each accepted transaction runs 32 bit-serial remainder steps for both
// operands at once, one fold step and a result step; add, subtract and compare stop there,
// multiply adds 16 steps of the interleaved multiply loop and inverse adds a search
// over candidate indices below m. a new transaction is taken only once the last one is
// done, also while its result waits in the output register. synchronous reset sets modulus to 2.
module modular_arithmetic_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [2:0]                               req_cmd,
   input  logic signed [mau_pkg::OPERAND_WIDTH-1:0] req_operand_a,
   input  logic signed [mau_pkg::OPERAND_WIDTH-1:0] req_operand_b,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [mau_pkg::MOD_WIDTH-1:0]            rsp_result,
   output logic                                     rsp_equal,
   output logic                                     rsp_less_than,
   output logic                                     rsp_greater_than,
   output logic                                     rsp_no_inverse,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mau_pkg::MOD_WIDTH-1:0]            csr_modulus
);

   mau_pkg::ctrl_cmd_type  cmd;
   mau_pkg::dp_status_type status;

   // sequencing
   mau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and registers
   mau_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .rsp_equal        (rsp_equal),
      .rsp_less_than    (rsp_less_than),
      .rsp_greater_than (rsp_greater_than),
      .rsp_no_inverse   (rsp_no_inverse),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_modulus      (csr_modulus)
   );

endmodule

[sv/mau_ctrl.sv]
// controller state machine of the modular arithmetic unit
module mau_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   input  mau_pkg::dp_status_type status,
   output mau_pkg::ctrl_cmd_type  cmd
);

   mau_pkg::state_type state_ff;
   mau_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mau_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mau_pkg::ST_REDUCE;
            end
         end
         mau_pkg::ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               state_in = mau_pkg::ST_FIX;
            end
         end
         mau_pkg::ST_FIX: begin
            cmd.fix = 1'b1;
            if (status.is_mul) begin
               state_in = mau_pkg::ST_MUL;
            end else if (status.is_inv) begin
               state_in = mau_pkg::ST_INV;
            end else begin
               state_in = mau_pkg::ST_DONE;
            end
         end
         mau_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = mau_pkg::ST_DONE;
            end
         end
         mau_pkg::ST_INV: begin
            if (status.inv_hit) begin
               state_in = mau_pkg::ST_DONE;
            end else if (status.inv_end) begin
               cmd.inv_fail = 1'b1;
               state_in     = mau_pkg::ST_DONE;
            end else begin
               cmd.inv_step = 1'b1;
            end
         end
         mau_pkg::ST_DONE: begin
            if (!status.rsp_busy || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = mau_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mau_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[sv/mau_dpath.sv]
// datapath of the modular arithmetic unit: reducers, step units and output register
`include "modular_arithmetic_unit_assert.svh"

module mau_dpath (
   input  logic                                       clock,
   input  logic                                       reset,
   input  mau_pkg::ctrl_cmd_type                      cmd,
   output mau_pkg::dp_status_type                     status,
   input  logic [2:0]                                 req_cmd,
   input  logic signed [mau_pkg::OPERAND_WIDTH-1:0]   req_operand_a,
   input  logic signed [mau_pkg::OPERAND_WIDTH-1:0]   req_operand_b,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [mau_pkg::MOD_WIDTH-1:0]              rsp_result,
   output logic                                       rsp_equal,
   output logic                                       rsp_less_than,
   output logic                                       rsp_greater_than,
   output logic                                       rsp_no_inverse,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [mau_pkg::MOD_WIDTH-1:0]              csr_modulus
);

   localparam int MW = mau_pkg::MOD_WIDTH;
   localparam int OW = mau_pkg::OPERAND_WIDTH;
   localparam int CW = mau_pkg::CNT_WIDTH;

   // modular add of two residues below m
   function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] x,
                                              input logic [MW-1:0] y,
                                              input logic [MW-1:0] m);
      logic [MW:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MW-1:0];
   endfunction

   // one restoring remainder step: shift in a bit, subtract m when it fits
   function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] r,
                                               input logic          b,
                                               input logic [MW-1:0] m);
      logic [MW:0] t;
      t = {r, b};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[MW-1:0];
   endfunction

   // configuration and control registers
   logic [MW-1:0] mod_ff, mod_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [2:0]    op_ff, op_in;
   logic [OW-1:0] mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic          neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   logic [MW-1:0] rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [MW-1:0] a_ff, a_in, b_ff, b_in;
   logic [MW-1:0] acc_ff, acc_in, idx_ff, idx_in;
   logic          noinv_ff, noinv_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] res_ff, res_in;
   logic          eq_ff, eq_in, lt_ff, lt_in, gt_ff, gt_in, ni_ff, ni_in;

   logic [MW-1:0] m_eff;
   logic [OW-1:0] ua, ub;
   logic [MW-1:0] dbl;
   logic [MW-1:0] sub_val;
   logic [3:0]    rsp_flags;

   // modulus below two acts as two
   assign m_eff = (mod_ff < MW'(2)) ? MW'(2) : mod_ff;
   assign ua    = $unsigned(req_operand_a);
   assign ub    = $unsigned(req_operand_b);
   assign dbl   = add_mod(acc_ff, acc_ff, m_eff);
   // wraps correctly: true difference is below m
   assign sub_val = (a_ff >= b_ff) ? (a_ff - b_ff) : (a_ff - b_ff + m_eff);

   // status to the controller
   assign status.red_last = (cnt_ff == CW'(OW - 1));
   assign status.mul_last = (cnt_ff == CW'(MW - 1));
   assign status.is_mul   = (op_ff == mau_pkg::OP_MUL);
   assign status.is_inv   = (op_ff == mau_pkg::OP_INV);
   assign status.inv_hit  = (acc_ff == MW'(1));
   assign status.inv_end  = (idx_ff == m_eff - MW'(1));
   assign status.rsp_busy = rsp_valid_ff;

   assign csr_ready = 1'b1;

   // next values
   always_comb begin
      mod_in       = mod_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      neg_a_in     = neg_a_ff;
      neg_b_in     = neg_b_ff;
      rem_a_in     = rem_a_ff;
      rem_b_in     = rem_b_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      noinv_in     = noinv_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      eq_in        = eq_ff;
      lt_in        = lt_ff;
      gt_in        = gt_ff;
      ni_in        = ni_ff;

      if (csr_valid) begin
         mod_in = csr_modulus;
      end

      // capture a transaction and take operand magnitudes
      if (cmd.load) begin
         op_in    = req_cmd;
         neg_a_in = ua[OW-1];
         neg_b_in = ub[OW-1];
         mag_a_in = ua[OW-1] ? (~ua + OW'(1)) : ua;
         mag_b_in = ub[OW-1] ? (~ub + OW'(1)) : ub;
         rem_a_in = '0;
         rem_b_in = '0;
         cnt_in   = '0;
      end

      // bit-serial remainder of both magnitudes
      if (cmd.red_step) begin
         rem_a_in = rem_step(rem_a_ff, mag_a_ff[OW-1], m_eff);
         rem_b_in = rem_step(rem_b_ff, mag_b_ff[OW-1], m_eff);
         mag_a_in = {mag_a_ff[OW-2:0], 1'b0};
         mag_b_in = {mag_b_ff[OW-2:0], 1'b0};
         cnt_in   = cnt_ff + CW'(1);
      end

      // canonical residues, negative operands folded back
      if (cmd.fix) begin
         a_in     = (neg_a_ff && (rem_a_ff != '0)) ? (m_eff - rem_a_ff) : rem_a_ff;
         b_in     = (neg_b_ff && (rem_b_ff != '0)) ? (m_eff - rem_b_ff) : rem_b_ff;
         acc_in   = '0;
         idx_in   = '0;
         noinv_in = 1'b0;
         cnt_in   = '0;
      end

      // interleaved modular multiply, msb of b first
      if (cmd.mul_step) begin
         acc_in = b_ff[MW-1] ? add_mod(dbl, a_ff, m_eff) : dbl;
         b_in   = {b_ff[MW-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
      end

      // inverse search: acc tracks a*idx mod m
      if (cmd.inv_step) begin
         acc_in = add_mod(acc_ff, a_ff, m_eff);
         idx_in = idx_ff + MW'(1);
      end

      if (cmd.inv_fail) begin
         noinv_in = 1'b1;
      end

      // output register
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         res_in       = '0;
         eq_in        = 1'b0;
         lt_in        = 1'b0;
         gt_in        = 1'b0;
         ni_in        = 1'b0;
         unique case (op_ff)
            mau_pkg::OP_ADD: res_in = add_mod(a_ff, b_ff, m_eff);
            mau_pkg::OP_SUB: res_in = sub_val;
            mau_pkg::OP_MUL: res_in = acc_ff;
            mau_pkg::OP_INV: begin
               res_in = noinv_ff ? '0 : idx_ff;
               ni_in  = noinv_ff;
            end
            mau_pkg::OP_CMP: begin
               eq_in = (a_ff == b_ff);
               lt_in = (a_ff < b_ff);
               gt_in = (a_ff > b_ff);
            end
            default: begin
               res_in = '0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff       <= MW'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      idx_ff   <= idx_in;
      noinv_ff <= noinv_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
      eq_ff    <= eq_in;
      lt_ff    <= lt_in;
      gt_ff    <= gt_in;
      ni_ff    <= ni_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = res_ff;
   assign rsp_equal        = eq_ff;
   assign rsp_less_than    = lt_ff;
   assign rsp_greater_than = gt_ff;
   assign rsp_no_inverse   = ni_ff;

   assign rsp_flags = {eq_ff, lt_ff, gt_ff, ni_ff};

   // checks
   `MAU_ASSERT_NEXT(a_residue_range, clock, reset, cmd.fix, (a_ff < m_eff) && (b_ff < m_eff), "residue not below modulus")
   `MAU_ASSERT_NEXT(result_range, clock, reset, cmd.finish, res_ff < m_eff, "result not below modulus")
   `MAU_ASSERT(flags_exclusive, clock, reset, !rsp_valid_ff || $onehot0(rsp_flags), "more than one flag set")
   `MAU_ASSERT(noinv_zero, clock, reset, !(rsp_valid_ff && ni_ff) || (res_ff == '0), "no inverse with nonzero result")

endmodule

[sim/mau_checker.sv]
// response checker for the modular arithmetic unit: predicts each transaction and compares
`timescale 1ns / 1ps

module mau_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic [2:0]                               req_cmd,
   input  logic signed [mau_pkg::OPERAND_WIDTH-1:0] req_operand_a,
   input  logic signed [mau_pkg::OPERAND_WIDTH-1:0] req_operand_b,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic [mau_pkg::MOD_WIDTH-1:0]            rsp_result,
   input  logic                                     rsp_equal,
   input  logic                                     rsp_less_than,
   input  logic                                     rsp_greater_than,
   input  logic                                     rsp_no_inverse,
   input  logic                                     csr_valid,
   input  logic                                     csr_ready,
   input  logic [mau_pkg::MOD_WIDTH-1:0]            csr_modulus,
   output int                                       errors,
   output int                                       outstanding,
   output int                                       checked
);

   import mau_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [MOD_WIDTH-1:0] result;
      logic                 equal;
      logic                 less_than;
      logic                 greater_than;
      logic                 no_inverse;
   } mau_outcome_type;

   // expected outcome plus the request that caused it, for reporting
   typedef struct {
      mau_outcome_type                  want;
      logic [2:0]                       cmd;
      logic signed [OPERAND_WIDTH-1:0]  a;
      logic signed [OPERAND_WIDTH-1:0]  b;
      logic [MOD_WIDTH-1:0]             m;
   } awaited_type;

   awaited_type          awaited_outcomes[$];
   logic [MOD_WIDTH-1:0] modulus_copy = 16'd2;

   // canonical residue in 0..m-1 of a two's complement operand
   function automatic longint canonical_residue(logic signed [OPERAND_WIDTH-1:0] v,
                                                longint m);
      longint r;
      r = longint'(v) % m;
      if (r < 0) r += m;
      return r;
   endfunction

   function automatic mau_outcome_type predict_outcome(logic [2:0] cmd,
                                                       logic signed [OPERAND_WIDTH-1:0] a,
                                                       logic signed [OPERAND_WIDTH-1:0] b,
                                                       logic [MOD_WIDTH-1:0] mod_reg);
      longint          m, ra, rb, g0, g1, s0, s1, q, t;
      mau_outcome_type o;
      o  = '0;
      // a modulus of zero or one behaves as two
      m  = (mod_reg < 2) ? 2 : longint'(mod_reg);
      ra = canonical_residue(a, m);
      rb = canonical_residue(b, m);
      case (cmd)
         OP_ADD: o.result = MOD_WIDTH'((ra + rb) % m);
         OP_SUB: o.result = MOD_WIDTH'((ra + m - rb) % m);
         OP_MUL: o.result = MOD_WIDTH'((ra * rb) % m);
         OP_INV: begin
            // extended euclid: gcd in g0, coefficient of a in s0
            g0 = m;
            g1 = ra;
            s0 = 0;
            s1 = 1;
            while (g1 != 0) begin
               q  = g0 / g1;
               t  = g0 - q * g1;
               g0 = g1;
               g1 = t;
               t  = s0 - q * s1;
               s0 = s1;
               s1 = t;
            end
            if (g0 == 1) o.result = MOD_WIDTH'(((s0 % m) + m) % m);
            else o.no_inverse = 1'b1;
         end
         OP_CMP: begin
            o.equal        = (ra == rb);
            o.less_than    = (ra < rb);
            o.greater_than = (ra > rb);
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : watch
      awaited_type     head;
      mau_outcome_type got;
      if (reset) begin
         awaited_outcomes.delete();
         modulus_copy <= 16'd2;
         outstanding  <= 0;
         errors       <= 0;
         checked      <= 0;
      end else begin
         // response side first, so a request on the same edge is never matched
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_result, rsp_equal, rsp_less_than, rsp_greater_than, rsp_no_inverse};
            checked <= checked + 1;
            if (awaited_outcomes.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("mau_checker: response result %0d with no request pending",
                           rsp_result);
               errors <= errors + 1;
            end else begin
               head = awaited_outcomes.pop_front();
               if (got !== head.want) begin
                  if (errors < MAX_REPORTS) begin
                     $display("mau_checker: mismatch for cmd %0d a %0d b %0d modulus %0d",
                              head.cmd, head.a, head.b, head.m);
                     $display("   expected result %0d eq %0b lt %0b gt %0b noinv %0b",
                              head.want.result, head.want.equal, head.want.less_than,
                              head.want.greater_than, head.want.no_inverse);
                     $display("   actual   result %0d eq %0b lt %0b gt %0b noinv %0b",
                              got.result, got.equal, got.less_than,
                              got.greater_than, got.no_inverse);
                  end
                  errors <= errors + 1;
               end
            end
         end
         // request side: predict with the modulus in force at acceptance
         if (req_valid && req_ready)
            awaited_outcomes.push_back(awaited_type'{predict_outcome(req_cmd, req_operand_a,
                                                                     req_operand_b,
                                                                     modulus_copy),
                                                     req_cmd, req_operand_a, req_operand_b,
                                                     modulus_copy});
         outstanding <= outstanding + ((req_valid && req_ready) ? 1 : 0)
                                    - ((rsp_valid && rsp_ready) ? 1 : 0);
         if (csr_valid && csr_ready) modulus_copy <= csr_modulus;
      end
   end

endmodule

[sim/tb.sv]
// stimulus and verdict for the modular arithmetic unit testbench
`timescale 1ns / 1ps

module tb;

   import mau_pkg::*;

   localparam int NUM_PHASES   = 15;
   localparam int PHASE_ITEMS  = 105;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_TAIL   = 60;
   localparam int LIMIT_CYCLES = 4_000_000;
   // above this modulus an inverse search is slow, so inverses are rationed
   localparam int SLOW_INV_MOD = 2048;
   localparam int INV_BUDGET   = 2;
   localparam int NUM_OPS      = int'(OP_CMP) + 1;
   localparam int CMD_UNUSED_LO = int'(OP_CMP) + 1;
   localparam int CMD_MAX      = 7;

   logic                             clock         = 1'b0;
   logic                             reset         = 1'b1;
   logic                             req_valid     = 1'b0;
   logic                             req_ready;
   logic [2:0]                       req_cmd       = '0;
   logic signed [OPERAND_WIDTH-1:0]  req_operand_a = '0;
   logic signed [OPERAND_WIDTH-1:0]  req_operand_b = '0;
   logic                             rsp_valid;
   logic                             rsp_ready     = 1'b0;
   logic [MOD_WIDTH-1:0]             rsp_result;
   logic                             rsp_equal;
   logic                             rsp_less_than;
   logic                             rsp_greater_than;
   logic                             rsp_no_inverse;
   logic                             csr_valid     = 1'b0;
   logic                             csr_ready;
   logic [MOD_WIDTH-1:0]             csr_modulus   = '0;

   int errors;
   int outstanding;
   int checked;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_reqs   = 0;
   int holds_seen   = 0;
   int hold_left    = 0;
   int cycle_count  = 0;
   int sent         = 0;
   int op_count[8];

   modular_arithmetic_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .rsp_equal        (rsp_equal),
      .rsp_less_than    (rsp_less_than),
      .rsp_greater_than (rsp_greater_than),
      .rsp_no_inverse   (rsp_no_inverse),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_modulus      (csr_modulus)
   );

   mau_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .rsp_equal        (rsp_equal),
      .rsp_less_than    (rsp_less_than),
      .rsp_greater_than (rsp_greater_than),
      .rsp_no_inverse   (rsp_no_inverse),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_modulus      (csr_modulus),
      .errors           (errors),
      .outstanding      (outstanding),
      .checked          (checked)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // response side: random back-pressure, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_seen != stall_reqs) begin
         holds_seen <= stall_reqs;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // one request transaction, with random gaps ahead of it
   task automatic send_op(logic [2:0] cmd, logic signed [OPERAND_WIDTH-1:0] a,
                          logic signed [OPERAND_WIDTH-1:0] b);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (!req_ready);
      op_count[cmd]++;
      sent++;
   endtask

   // stop sending and wait for every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_modulus(logic [MOD_WIDTH-1:0] value);
      drain();
      csr_valid   <= 1'b1;
      csr_modulus <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // operand mix: extremes, small values, multiples of m, full random
   function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand(int unsigned m);
      int unsigned k;
      k = $urandom_range(0, 6);
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000 + $urandom_range(0, 3);
         1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 2 * m);
         3: return -$urandom_range(0, 2 * m);
         4: return k * m;
         5: return -(k * m);
         default: return $urandom();
      endcase
   endfunction

   initial begin : stimulus
      int          mode;
      int          sel;
      int          inv_budget;
      int unsigned eff_m;
      logic [2:0]  cmd;
      int unsigned phase_mod[NUM_PHASES];

      phase_mod = '{0, 65535, 12, 1, 97, 65521, 3, 0, 65534, 1000, 0, 256, 7, 2, 0};
      phase_mod[7]  = $urandom_range(2, 300);
      phase_mod[10] = $urandom_range(2, 65535);
      phase_mod[14] = $urandom_range(2, 50);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: modulus left at its reset value
      send_op(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_op(OP_INV, 1, 0);
      send_op(OP_INV, -2, 0);
      send_op(OP_CMP, -1, 1);

      // directed: composite modulus
      set_modulus(12);
      send_op(OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_op(OP_ADD, 32'sh8000_0000, 32'sh8000_0000);
      send_op(OP_ADD, -24, 0);
      send_op(OP_SUB, 5, 17);
      send_op(OP_SUB, -12, 24);
      send_op(OP_SUB, 0, 1);
      send_op(OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_op(OP_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_op(OP_MUL, -1, -1);
      send_op(OP_INV, 5, 32'sh7FFF_FFFF);
      send_op(OP_INV, 6, 1);
      send_op(OP_INV, 0, 0);
      send_op(OP_INV, -1, -1);
      send_op(OP_CMP, 3, 15);
      send_op(OP_CMP, -1, 0);
      send_op(OP_CMP, 2, 7);
      // unused operation codes give all-zero responses
      for (int c = CMD_UNUSED_LO; c <= CMD_MAX; c++) send_op(c[2:0], 7, -3);

      // random phases, one modulus each; idling pattern by third of the run
      for (int p = 0; p < NUM_PHASES; p++) begin
         mode         = (p * 3) / NUM_PHASES;
         req_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 46 : 0;
         rsp_idle_pct <= (mode == 0) ? 46 : (mode == 1) ? 7 : 0;
         set_modulus(phase_mod[p][MOD_WIDTH-1:0]);
         eff_m      = (phase_mod[p] < 2) ? 2 : phase_mod[p];
         inv_budget = INV_BUDGET;
         // long response hold-off while requests keep coming
         if (p == 2 || p == 10) stall_reqs <= stall_reqs + 1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 4 && i == PHASE_ITEMS / 2) drain();
            sel = $urandom_range(0, 19);
            if (sel >= 18) cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_MAX));
            else cmd = 3'(sel % NUM_OPS);
            if (cmd == OP_INV && eff_m > SLOW_INV_MOD) begin
               if (inv_budget == 0) cmd = OP_MUL;
               else inv_budget--;
            end
            send_op(cmd, pick_operand(eff_m), pick_operand(eff_m));
         end
      end

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("tb: %0d requests over %0d modulus settings, %0d responses checked",
               sent, NUM_PHASES + 2, checked);
      $display("tb: add %0d sub %0d mul %0d inv %0d cmp %0d unused codes %0d",
               op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_INV],
               op_count[OP_CMP], op_count[5] + op_count[6] + op_count[7]);
      if (errors == 0 && outstanding == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
